// File: src/mtc_pkg.sv
// Shared types and constants for the MIDI time code generator.
// Used by mtc_front, mtc_back and smpte_timecode_mtc_generator; no dependencies.
package mtc_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_ADV   = 3'd1,
		OP_REW   = 3'd2,
		OP_FULL  = 3'd3,
		OP_QTR   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_REW,
		ST_UPD,
		ST_MSG
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] count;
	} q_item_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] SYSEX_START  = 8'hF0;
	localparam logic [7:0] SYSEX_END    = 8'hF7;
	localparam logic [7:0] SYSEX_RT_ID  = 8'h7F;
	localparam logic [7:0] MTC_SUB_ID   = 8'h01;
	localparam logic [7:0] QF_STATUS    = 8'hF1;
	localparam logic [7:0] QF_PIECE7    = 8'h70;
	localparam logic [3:0] NIBBLE_MASK  = 4'hF;
	localparam logic [3:0] CHG_FRAMES   = 4'h1;
	localparam logic [3:0] CHG_ALL      = 4'hF;
	localparam logic [3:0] FULL_LAST    = 4'd9;
	localparam logic [3:0] QTR_LAST     = 4'd1;

	function automatic logic [4:0] fps_of(input logic [1:0] rate);
		logic [4:0] f;
		unique case (rate)
			2'd0: f = 5'd24;
			2'd1: f = 5'd25;
			2'd2: f = 5'd30;
			default: f = 5'd30;
		endcase
		return f;
	endfunction

endpackage

// File: src/mtc_front.sv
// Front end: accepts input items, drops held messages and unknown commands,
// and queues the rest for the back end. Depends on mtc_pkg.
module mtc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        cmd,
	input  logic [7:0]        frame_count,
	input  logic              hold,
	output logic              q_valid,
	output mtc_pkg::q_item_t  q_item,
	input  logic              q_pop
);

	mtc_pkg::q_item_t                   mem_q [mtc_pkg::QUEUE_DEPTH];
	logic [mtc_pkg::QUEUE_AW-1:0]       wr_ptr_q;
	logic [mtc_pkg::QUEUE_AW-1:0]       rd_ptr_q;
	logic [mtc_pkg::QUEUE_CW-1:0]       count_q;
	logic                               keep;
	logic                               push;

	always_comb begin
		unique case (mtc_pkg::op_t'(cmd))
			mtc_pkg::OP_CLEAR, mtc_pkg::OP_ADV, mtc_pkg::OP_REW: keep = 1'b1;
			mtc_pkg::OP_FULL, mtc_pkg::OP_QTR:                 keep = !hold;
			default:                                           keep = 1'b0;
		endcase
	end

	assign in_stall = (count_q == mtc_pkg::QUEUE_CW'(mtc_pkg::QUEUE_DEPTH));
	assign push     = in_valid && !in_stall && keep;
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	function automatic logic [mtc_pkg::QUEUE_AW-1:0] next_ptr(
		input logic [mtc_pkg::QUEUE_AW-1:0] p);
		if (p == mtc_pkg::QUEUE_AW'(mtc_pkg::QUEUE_DEPTH - 1))
			return '0;
		return p + mtc_pkg::QUEUE_AW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q].op    <= mtc_pkg::op_t'(cmd);
			mem_q[wr_ptr_q].count <= frame_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (q_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + mtc_pkg::QUEUE_CW'(1);
				2'b01:   count_q <= count_q - mtc_pkg::QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !push) |=> (count_q == $past(count_q) - mtc_pkg::QUEUE_CW'(1)))
		else $error("queue count lost track of a pop");

endmodule

// File: src/mtc_back.sv
// Back end: runs queued commands on the timecode, iterating carries and borrows
// one second per cycle, and drives the registered result channel. Depends on mtc_pkg.
module mtc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  mtc_pkg::q_item_t  q_item,
	output logic              q_pop,
	input  logic [1:0]        frame_rate,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        out_byte,
	output logic              is_message,
	output logic              last,
	output logic [3:0]        changed_digits
);

	mtc_pkg::state_t state_q, state_d;

	logic [4:0] frames_q;
	logic [5:0] seconds_q;
	logic [5:0] minutes_q;
	logic [4:0] hours_q;
	logic [2:0] piece_q;
	logic [1:0] rate_q;
	logic [8:0] f_q;
	logic [7:0] left_q;
	logic [3:0] chg_q;
	logic [3:0] idx_q;
	logic       full_q;
	logic [7:0] qbyte_q;
	logic       out_valid_q;

	logic [4:0] fps;
	logic       fwd_carry;
	logic [4:0] step;
	logic       rew_borrow;
	logic       out_free;
	logic       msg_last;
	logic       load_upd;
	logic       load_msg;
	logic [7:0] msg_byte;

	function automatic logic [7:0] quarter_byte(
		input logic [2:0] p, input logic [1:0] rate, input logic [4:0] hr,
		input logic [5:0] mn, input logic [5:0] sc, input logic [4:0] fr);
		logic [7:0] v;
		logic [3:0] nib;
		unique case (p[2:1])
			2'd0: v = {3'd0, fr};
			2'd1: v = {2'd0, sc};
			2'd2: v = {2'd0, mn};
			default: v = {3'd0, hr};
		endcase
		nib = (p[0] ? v[7:4] : v[3:0]) & mtc_pkg::NIBBLE_MASK;
		if (p == 3'd7)
			return mtc_pkg::QF_PIECE7 | {5'd0, rate, 1'b0} | {7'd0, hr[4]};
		return {1'b0, p, nib};
	endfunction

	assign fps        = mtc_pkg::fps_of(rate_q);
	assign fwd_carry  = (f_q >= {4'd0, fps});
	assign step       = (left_q >= {3'd0, fps}) ? fps : left_q[4:0];
	assign rew_borrow = (frames_q < step);
	assign out_free   = !out_valid_q || !out_stall;
	assign msg_last   = full_q ? (idx_q == mtc_pkg::FULL_LAST) : (idx_q == mtc_pkg::QTR_LAST);

	always_comb begin
		if (full_q) begin
			unique case (idx_q)
				4'd0:    msg_byte = mtc_pkg::SYSEX_START;
				4'd1:    msg_byte = mtc_pkg::SYSEX_RT_ID;
				4'd2:    msg_byte = mtc_pkg::SYSEX_RT_ID;
				4'd3:    msg_byte = mtc_pkg::MTC_SUB_ID;
				4'd4:    msg_byte = mtc_pkg::MTC_SUB_ID;
				4'd5:    msg_byte = {1'b0, rate_q, hours_q};
				4'd6:    msg_byte = {2'd0, minutes_q};
				4'd7:    msg_byte = {2'd0, seconds_q};
				4'd8:    msg_byte = {3'd0, frames_q};
				default: msg_byte = mtc_pkg::SYSEX_END;
			endcase
		end else begin
			msg_byte = (idx_q == '0) ? mtc_pkg::QF_STATUS : qbyte_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtc_pkg::ST_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						mtc_pkg::OP_CLEAR: state_d = mtc_pkg::ST_UPD;
						mtc_pkg::OP_ADV:   state_d = mtc_pkg::ST_FWD;
						mtc_pkg::OP_REW:   state_d = mtc_pkg::ST_REW;
						default:           state_d = mtc_pkg::ST_MSG;
					endcase
				end
			end
			mtc_pkg::ST_FWD: if (!fwd_carry) state_d = mtc_pkg::ST_UPD;
			mtc_pkg::ST_REW: if (left_q == '0) state_d = mtc_pkg::ST_UPD;
			mtc_pkg::ST_UPD: if (out_free) state_d = mtc_pkg::ST_IDLE;
			mtc_pkg::ST_MSG: if (out_free && msg_last) state_d = mtc_pkg::ST_IDLE;
			default:         state_d = mtc_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop    = (state_q == mtc_pkg::ST_IDLE) && q_valid;
		load_upd = (state_q == mtc_pkg::ST_UPD) && out_free;
		load_msg = (state_q == mtc_pkg::ST_MSG) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mtc_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q  <= '0;
			seconds_q <= '0;
			minutes_q <= '0;
			hours_q   <= '0;
			piece_q   <= '0;
			rate_q    <= '0;
			f_q       <= '0;
			left_q    <= '0;
			chg_q     <= '0;
			idx_q     <= '0;
			full_q    <= 1'b0;
			qbyte_q   <= '0;
		end else if (q_pop) begin
			unique case (q_item.op)
				mtc_pkg::OP_CLEAR: begin
					frames_q  <= '0;
					seconds_q <= '0;
					minutes_q <= '0;
					hours_q   <= '0;
					piece_q   <= '0;
					rate_q    <= frame_rate;
					chg_q     <= mtc_pkg::CHG_ALL;
				end
				mtc_pkg::OP_ADV: begin
					f_q   <= {4'd0, frames_q} + {1'b0, q_item.count};
					chg_q <= mtc_pkg::CHG_FRAMES;
				end
				mtc_pkg::OP_REW: begin
					left_q <= q_item.count;
					chg_q  <= mtc_pkg::CHG_FRAMES;
				end
				mtc_pkg::OP_FULL: begin
					rate_q  <= frame_rate;
					piece_q <= '0;
					idx_q   <= '0;
					full_q  <= 1'b1;
				end
				default: begin
					qbyte_q <= quarter_byte(piece_q, rate_q, hours_q, minutes_q,
						seconds_q, frames_q);
					piece_q <= piece_q + 3'd1;
					idx_q   <= '0;
					full_q  <= 1'b0;
				end
			endcase
		end else if (state_q == mtc_pkg::ST_FWD) begin
			if (fwd_carry) begin
				// carry one second
				f_q      <= f_q - {4'd0, fps};
				chg_q[1] <= 1'b1;
				if (seconds_q >= 6'd59) begin
					seconds_q <= '0;
					chg_q[2]  <= 1'b1;
					if (minutes_q >= 6'd59) begin
						minutes_q <= '0;
						chg_q[3]  <= 1'b1;
						hours_q   <= (hours_q >= 5'd23) ? 5'd0 : hours_q + 5'd1;
					end else begin
						minutes_q <= minutes_q + 6'd1;
					end
				end else begin
					seconds_q <= seconds_q + 6'd1;
				end
			end else begin
				frames_q <= f_q[4:0];
			end
		end else if (state_q == mtc_pkg::ST_REW && left_q != '0) begin
			left_q <= left_q - {3'd0, step};
			if (!rew_borrow) begin
				frames_q <= frames_q - step;
			end else begin
				// borrow one second
				frames_q <= frames_q + fps - step;
				chg_q[1] <= 1'b1;
				if (seconds_q == '0) begin
					seconds_q <= 6'd59;
					chg_q[2]  <= 1'b1;
					if (minutes_q == '0) begin
						minutes_q <= 6'd59;
						chg_q[3]  <= 1'b1;
						hours_q   <= (hours_q == '0) ? 5'd23 : hours_q - 5'd1;
					end else begin
						minutes_q <= minutes_q - 6'd1;
					end
				end else begin
					seconds_q <= seconds_q - 6'd1;
				end
			end
		end else if (load_msg) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_upd || load_msg)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_upd) begin
			out_byte       <= '0;
			is_message     <= 1'b0;
			last           <= 1'b1;
			changed_digits <= chg_q;
		end else if (load_msg) begin
			out_byte       <= msg_byte;
			is_message     <= 1'b1;
			last           <= msg_last;
			changed_digits <= '0;
		end
	end

	assign out_valid = out_valid_q;

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		(frames_q <= 5'd29) && (seconds_q <= 6'd59) && (minutes_q <= 6'd59)
		&& (hours_q <= 5'd23))
		else $error("timecode digit out of range");

	a_update_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !is_message) |-> (last && out_byte == '0))
		else $error("time update result not a single final item");

	a_msg_time_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtc_pkg::ST_MSG) |=> ($stable(hours_q) && $stable(minutes_q)
		&& $stable(seconds_q) && $stable(frames_q)))
		else $error("timecode moved while a message was sent");

	a_msg_no_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && is_message) |-> (changed_digits == '0))
		else $error("message item carries changed digits");

endmodule

// File: src/smpte_timecode_mtc_generator.sv
// MIDI time code generator top level: rate register, front end queue, back end.
// An accepted item is queued by the front end and popped by the back end while idle.
// Clear then loads the output register; advance first carries n seconds (n <= 11) and
// rewind first takes k = ceil(frame_count / fps) steps (k <= 11) before loading it;
// message bytes load one per cycle while not stalled. Items are run one at a time.
// Reset clears timecode, piece index, latched rate, rate register, queue and output valid.
module smpte_timecode_mtc_generator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  logic [7:0] frame_count,
	input  logic       hold,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       is_message,
	output logic       last,
	output logic [3:0] changed_digits,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] frame_rate
);

	logic [1:0]       frame_rate_q;
	logic             q_valid;
	logic             q_pop;
	mtc_pkg::q_item_t q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			frame_rate_q <= '0;
		else if (cfg_valid && cfg_ready)
			frame_rate_q <= frame_rate;
	end

	mtc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.frame_count (frame_count),
		.hold        (hold),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	mtc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_item         (q_item),
		.q_pop          (q_pop),
		.frame_rate     (frame_rate_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.is_message     (is_message),
		.last           (last),
		.changed_digits (changed_digits)
	);

endmodule

// File: test/smpte_timecode_mtc_generator_tb.sv
// Testbench for the MIDI time code generator: drives commands and rate writes,
// predicts every result byte and digit mask, and checks each item on the output.
// Depends on mtc_pkg and smpte_timecode_mtc_generator.
`timescale 1ns / 100ps

module smpte_timecode_mtc_generator_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 15;

	localparam logic [1:0] RATE_24   = 2'd0;
	localparam logic [1:0] RATE_25   = 2'd1;
	localparam logic [1:0] RATE_30DF = 2'd2;
	localparam logic [1:0] RATE_30   = 2'd3;

	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [7:0] data;
		logic       is_msg;
		logic       is_last;
		logic [3:0] digits;
	} mtc_result_t;

	class mtc_scoreboard;
		mtc_result_t pending[$];
		int          errors;
		logic [4:0]  fr;
		logic [5:0]  sc;
		logic [5:0]  mn;
		logic [4:0]  hr;
		logic [2:0]  piece;
		logic [1:0]  rate_used;
		logic [1:0]  rate_reg;

		function new();
			errors = 0;
			fr = '0;
			sc = '0;
			mn = '0;
			hr = '0;
			piece = '0;
			rate_used = RATE_24;
			rate_reg = RATE_24;
		endfunction

		function void set_rate(logic [1:0] v);
			rate_reg = v;
		endfunction

		function int frames_per_sec();
			int f;
			case (rate_used)
				RATE_24: f = 24;
				RATE_25: f = 25;
				default: f = 30;
			endcase
			return f;
		endfunction

		function void push(logic [7:0] d, logic m, logic l, logic [3:0] g);
			mtc_result_t r;
			r.data = d;
			r.is_msg = m;
			r.is_last = l;
			r.digits = g;
			pending.push_back(r);
		endfunction

		function logic [3:0] step_up(logic [7:0] n);
			int f;
			int fps;
			logic [3:0] g;
			fps = frames_per_sec();
			f = fr + n;
			g = 4'b0001;
			while (f >= fps) begin
				f -= fps;
				g |= 4'b0010;
				if (sc == 6'd59) begin
					sc = '0;
					g |= 4'b0100;
					if (mn == 6'd59) begin
						mn = '0;
						g |= 4'b1000;
						hr = (hr == 5'd23) ? 5'd0 : hr + 5'd1;
					end else begin
						mn = mn + 6'd1;
					end
				end else begin
					sc = sc + 6'd1;
				end
			end
			fr = f[4:0];
			return g;
		endfunction

		function logic [3:0] step_down(logic [7:0] n);
			int left;
			int stp;
			int fps;
			int f;
			logic [3:0] g;
			fps = frames_per_sec();
			left = n;
			g = 4'b0001;
			while (left > 0) begin
				stp = (left >= fps) ? fps : left;
				left -= stp;
				if (fr >= stp) begin
					fr = fr - stp[4:0];
				end else begin
					f = fr + fps - stp;
					fr = f[4:0];
					g |= 4'b0010;
					if (sc == 6'd0) begin
						sc = 6'd59;
						g |= 4'b0100;
						if (mn == 6'd0) begin
							mn = 6'd59;
							g |= 4'b1000;
							hr = (hr == 5'd0) ? 5'd23 : hr - 5'd1;
						end else begin
							mn = mn - 6'd1;
						end
					end else begin
						sc = sc - 6'd1;
					end
				end
			end
			return g;
		endfunction

		function void note_item(logic [2:0] c, logic [7:0] n, logic h);
			logic [7:0] msg [10];
			logic [7:0] v;
			logic [3:0] nib;
			logic [7:0] b;
			case (c)
				mtc_pkg::OP_CLEAR: begin
					fr = '0;
					sc = '0;
					mn = '0;
					hr = '0;
					piece = '0;
					rate_used = rate_reg;
					push(8'h00, 1'b0, 1'b1, 4'hF);
				end
				mtc_pkg::OP_ADV: push(8'h00, 1'b0, 1'b1, step_up(n));
				mtc_pkg::OP_REW: push(8'h00, 1'b0, 1'b1, step_down(n));
				mtc_pkg::OP_FULL: begin
					if (!h) begin
						rate_used = rate_reg;
						piece = '0;
						// F0 7F 7F 01 01 hr mn sc fr F7
						msg[0] = 8'hF0;
						msg[1] = 8'h7F;
						msg[2] = 8'h7F;
						msg[3] = 8'h01;
						msg[4] = 8'h01;
						msg[5] = {1'b0, rate_used, hr};
						msg[6] = {2'b00, mn};
						msg[7] = {2'b00, sc};
						msg[8] = {3'b000, fr};
						msg[9] = 8'hF7;
						for (int k = 0; k < 10; k++)
							push(msg[k], 1'b1, k == 9, 4'h0);
					end
				end
				mtc_pkg::OP_QTR: begin
					if (!h) begin
						case (piece[2:1])
							2'd0: v = {3'b000, fr};
							2'd1: v = {2'b00, sc};
							2'd2: v = {2'b00, mn};
							default: v = {3'b000, hr};
						endcase
						nib = piece[0] ? v[7:4] : v[3:0];
						if (piece == 3'd7)
							b = {4'h7, 1'b0, rate_used, hr > 5'd15};
						else
							b = {1'b0, piece, nib};
						piece = piece + 3'd1;
						push(8'hF1, 1'b1, 1'b0, 4'h0);
						push(b, 1'b1, 1'b1, 4'h0);
					end
				end
				default: ;
			endcase
		endfunction

		function void cmp(string what, logic [7:0] e, logic [7:0] g);
			if (e !== g) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, e, g);
			end
		endfunction

		function void check_result(logic [7:0] d, logic m, logic l, logic [3:0] g);
			mtc_result_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, actual %0h/%0b/%0b/%0h",
					$time, d, m, l, g);
			end else begin
				e = pending.pop_front();
				cmp("out_byte", e.data, d);
				cmp("is_message", {7'd0, e.is_msg}, {7'd0, m});
				cmp("last", {7'd0, e.is_last}, {7'd0, l});
				cmp("changed_digits", {4'd0, e.digits}, {4'd0, g});
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] cmd = mtc_pkg::OP_CLEAR;
	logic [7:0] frame_count = 8'd0;
	logic       hold = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       is_message;
	logic       last;
	logic [3:0] changed_digits;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] frame_rate = RATE_24;

	mtc_scoreboard sb;
	logic no_idle = 1'b0;
	int   stall_left = 0;
	int   stall_pick;
	int   quiet_cycles = 0;

	smpte_timecode_mtc_generator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.frame_count    (frame_count),
		.hold           (hold),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.is_message     (is_message),
		.last           (last),
		.changed_digits (changed_digits),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.frame_rate     (frame_rate)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_byte, is_message, last, changed_digits);
		if (no_idle || !arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 70) begin
				out_stall <= 1'b0;
			end else if (stall_pick < 95) begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_left <= $urandom_range(10, 30);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("smpte_timecode_mtc_generator_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic idle_gap();
		int r;
		int g;
		g = 0;
		if (!no_idle) begin
			r = $urandom_range(0, 99);
			if (r >= 90)
				g = $urandom_range(10, 40);
			else if (r >= 50)
				g = $urandom_range(1, 3);
		end
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_item(logic [2:0] c, logic [7:0] n, logic h);
		in_valid <= 1'b1;
		cmd <= c;
		frame_count <= n;
		hold <= h;
		do @(posedge clk); while (in_stall);
		sb.note_item(c, n, h);
		idle_gap();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_rate(logic [1:0] v);
		cfg_valid <= 1'b1;
		frame_rate <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.set_rate(v);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return (r < 7) ? 8'd0 : 8'd255;
		else if (r < 60)
			return 8'($urandom_range(0, 31));
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_item(output int counted);
		int r;
		logic [2:0] c;
		logic h;
		r = $urandom_range(0, 99);
		h = ($urandom_range(0, 9) == 0);
		if (r < 30)
			c = mtc_pkg::OP_ADV;
		else if (r < 55)
			c = mtc_pkg::OP_REW;
		else if (r < 80)
			c = mtc_pkg::OP_QTR;
		else if (r < 88)
			c = mtc_pkg::OP_FULL;
		else if (r < 93)
			c = mtc_pkg::OP_CLEAR;
		else
			c = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
		counted = (c >= CMD_SPARE_FIRST
			|| (h && (c == mtc_pkg::OP_FULL || c == mtc_pkg::OP_QTR))) ? 0 : 1;
		send_item(c, pick_count(), h);
	endtask

	initial begin
		int done;
		int counted;
		logic [1:0] rate;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: borrow through every digit, all pieces, wrap forward
		write_rate(RATE_30);
		send_item(mtc_pkg::OP_CLEAR, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_REW, 8'd1, 1'b0);
		repeat (8) send_item(mtc_pkg::OP_QTR, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_FULL, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_ADV, 8'd1, 1'b0);
		send_item(mtc_pkg::OP_ADV, 8'd255, 1'b0);
		send_item(mtc_pkg::OP_REW, 8'd255, 1'b1);
		send_item(mtc_pkg::OP_ADV, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_REW, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_FULL, 8'd0, 1'b1);
		send_item(mtc_pkg::OP_QTR, 8'd0, 1'b1);
		send_item(CMD_SPARE_FIRST, 8'd0, 1'b0);
		send_item(CMD_SPARE_MID, 8'd0, 1'b0);
		send_item(CMD_SPARE_LAST, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_CLEAR, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_ADV, 8'd29, 1'b0);
		// frames left beyond a slower rate
		wait_drained();
		write_rate(RATE_24);
		send_item(mtc_pkg::OP_FULL, 8'd0, 1'b0);
		send_item(mtc_pkg::OP_REW, 8'd3, 1'b0);
		send_item(mtc_pkg::OP_ADV, 8'd0, 1'b0);

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: rate = RATE_25;
				1: rate = RATE_30DF;
				2: rate = RATE_24;
				3: rate = RATE_30;
				default: rate = 2'($urandom_range(0, 3));
			endcase
			no_idle = (ph == 1);
			write_rate(rate);
			done = 0;
			if ($urandom_range(0, 1) == 0) begin
				send_item(mtc_pkg::OP_CLEAR, pick_count(), 1'($urandom_range(0, 1)));
				done++;
			end
			while (done < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 19) == 0) begin
					send_item(mtc_pkg::OP_FULL, pick_count(), 1'b0);
					repeat (8) send_item(mtc_pkg::OP_QTR, pick_count(), 1'b0);
					done += 9;
				end else begin
					random_item(counted);
					done += counted;
				end
			end
		end

		no_idle = 1'b0;
		wait_drained();
		if (sb.errors == 0)
			$display("smpte_timecode_mtc_generator_tb: done, clean");
		else
			$display("smpte_timecode_mtc_generator_tb: done, errors");
		$finish;
	end

endmodule
